FILE: rtl/log_frame_checker_assert.svh
// Assertion macros shared by the log frame checker modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LOG_FRAME_CHECKER_ASSERT_SVH
`define LOG_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define LFC_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define LFC_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lfc_pkg.sv
// Shared types, codes and helper functions of the log frame checker.
// Depends on nothing; used by every RTL module of the block.
package lfc_pkg;

   // Defaults of the top-level parameters
   localparam int HEADER_BYTES_DEF  = 10;
   localparam int POSITION_BITS_DEF = 16;

   // CRC-32 (reflected) constants
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // Frame magic "LFDB", first byte in the low bits
   localparam logic [31:0] MAGIC_WORD = 32'h4244_464C;

   // Configuration register indexes and reset values
   localparam int          CSR_INDEX_BITS    = 2;
   localparam logic [1:0]  CSR_COMMIT_MARKER = 2'd0;
   localparam logic [1:0]  CSR_MAX_PAYLOAD   = 2'd1;
   localparam logic [31:0] COMMIT_MARKER_RST = 32'hFFFF_FFFF;
   localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd4096;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_VERDICT = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // Frame status codes
   localparam logic [2:0] ST_DATA_OK   = 3'd0;
   localparam logic [2:0] ST_COMMIT_OK = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
   localparam logic [2:0] ST_CRC_BAD   = 3'd3;
   localparam logic [2:0] ST_TOO_LONG  = 3'd4;
   localparam logic [2:0] ST_TRUNCATED = 3'd5;

   // Result queue depth (power of two) and packed result width
   localparam int QUEUE_DEPTH   = 4;
   localparam int RSP_DATA_BITS = 112;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] page_number;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [2:0]  frame_status;
      logic [31:0] page_count;
      logic [15:0] commits_seen;
      logic        last_of_run;
   } lfc_result_type;

   // Results made by one input item: count is 0, 1 or 2, slot0 goes first
   typedef struct packed {
      logic [1:0]     count;
      lfc_result_type slot0;
      lfc_result_type slot1;
   } lfc_push_type;

   // Advance a reflected CRC-32 by one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   // Replace byte idx of a little-endian word
   function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] idx,
                                            input logic [7:0] b);
      logic [31:0] w;
      w = word;
      w[{idx, 3'b000} +: 8] = b;
      return w;
   endfunction

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      return MAGIC_WORD[{idx, 3'b000} +: 8];
   endfunction

endpackage

FILE: rtl/lfc_parser.sv
// Frame parser of the log frame checker: state, CRC and verdict logic.
// Depends on lfc_pkg and log_frame_checker_assert.svh.
`include "log_frame_checker_assert.svh"

module lfc_parser #(
   parameter int HEADER_BYTES  = lfc_pkg::HEADER_BYTES_DEF,
   parameter int POSITION_BITS = lfc_pkg::POSITION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_accept,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  logic [31:0]          commit_marker,
   input  logic [15:0]          max_payload,
   output lfc_pkg::lfc_push_type push
);

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_FRAME   = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   localparam logic [3:0] HEADER_RST = 4'(HEADER_BYTES);
   localparam logic [1:0] PHASE_RST  = (HEADER_BYTES == 0) ? PH_FRAME : PH_HEADER;

   logic [1:0]               phase_ff, phase_in;
   logic [3:0]               header_left_ff, header_left_in;
   logic [3:0]               field_byte_ff, field_byte_in;
   logic [31:0]              page_ff, page_in;
   logic [31:0]              length_ff, length_in;
   logic [31:0]              exp_crc_ff, exp_crc_in;
   logic [31:0]              run_crc_ff, run_crc_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [31:0]              count_ff, count_in;
   logic [15:0]              commits_ff, commits_in;
   logic                     halted_ff, halted_in;
   logic                     magic_ok_ff, magic_ok_in;

   // Step the parser by one byte and build its results
   always_comb begin
      logic                   ended;
      logic                   do_close;
      logic                   has_payload;
      logic                   open;
      logic [2:0]             st;
      lfc_pkg::lfc_result_type extra;

      phase_in       = phase_ff;
      header_left_in = header_left_ff;
      field_byte_in  = field_byte_ff;
      page_in        = page_ff;
      length_in      = length_ff;
      exp_crc_in     = exp_crc_ff;
      run_crc_in     = run_crc_ff;
      pos_in         = pos_ff;
      count_in       = count_ff;
      commits_in     = commits_ff;
      halted_in      = halted_ff;
      magic_ok_in    = magic_ok_ff;
      ended          = 1'b0;
      do_close       = 1'b0;
      has_payload    = 1'b0;
      open           = 1'b0;
      st             = lfc_pkg::ST_DATA_OK;
      extra          = '0;
      push           = '0;

      if (in_accept) begin
         if (halted_ff) begin
            // drop bytes until the end of the log
         end else if (phase_ff == PH_HEADER) begin
            header_left_in = header_left_ff - 4'd1;
            if (header_left_in == 4'd0) begin
               phase_in = PH_FRAME;
            end
         end else if (phase_ff == PH_FRAME) begin
            if (field_byte_ff == 4'd0) begin
               magic_ok_in = 1'b1;
               page_in     = '0;
               length_in   = '0;
               exp_crc_in  = '0;
               count_in    = '0;
            end
            unique case (field_byte_ff[3:2])
               2'd0: begin
                  if (in_byte != lfc_pkg::magic_byte(field_byte_ff[1:0])) begin
                     magic_ok_in = 1'b0;
                  end
               end
               2'd1: page_in    = lfc_pkg::put_byte(page_in, field_byte_ff[1:0], in_byte);
               2'd2: length_in  = lfc_pkg::put_byte(length_in, field_byte_ff[1:0], in_byte);
               default: exp_crc_in = lfc_pkg::put_byte(exp_crc_in, field_byte_ff[1:0], in_byte);
            endcase
            field_byte_in = field_byte_ff + 4'd1;
            // header complete: check magic, then length
            if (field_byte_ff == 4'd15) begin
               run_crc_in = lfc_pkg::ALL_ONES;
               pos_in     = '0;
               ended      = 1'b1;
               if (!magic_ok_in) begin
                  st        = lfc_pkg::ST_BAD_MAGIC;
                  halted_in = 1'b1;
               end else if (length_in > {16'd0, max_payload}) begin
                  st        = lfc_pkg::ST_TOO_LONG;
                  halted_in = 1'b1;
               end else if (length_in == 32'd0) begin
                  do_close = 1'b1;
               end else begin
                  ended    = 1'b0;
                  phase_in = PH_PAYLOAD;
               end
            end
         end else begin
            // pass the payload byte and fold it into the CRC
            has_payload             = 1'b1;
            push.slot0.kind         = lfc_pkg::KIND_PAYLOAD;
            push.slot0.page_number  = page_ff;
            push.slot0.data_byte    = in_byte;
            push.slot0.byte_index   = 16'(pos_ff);
            push.slot0.frame_status = lfc_pkg::ST_DATA_OK;
            push.slot0.commits_seen = commits_ff;
            run_crc_in = lfc_pkg::crc_byte(run_crc_ff, in_byte);
            if (pos_ff < POSITION_BITS'(4)) begin
               count_in = lfc_pkg::put_byte(count_ff, pos_ff[1:0], in_byte);
            end
            pos_in = pos_ff + 1'b1;
            if (32'(pos_in) == length_ff) begin
               ended    = 1'b1;
               do_close = 1'b1;
            end
         end

         // close the frame: check the CRC, count commits
         if (do_close) begin
            if ((run_crc_in ^ lfc_pkg::ALL_ONES) != exp_crc_in) begin
               halted_in = 1'b1;
               st        = lfc_pkg::ST_CRC_BAD;
            end else begin
               if (page_in == commit_marker) begin
                  if (commits_in != 16'hFFFF) begin
                     commits_in = commits_in + 16'd1;
                  end
                  st = lfc_pkg::ST_COMMIT_OK;
               end else begin
                  st = lfc_pkg::ST_DATA_OK;
               end
               phase_in      = PH_FRAME;
               field_byte_in = 4'd0;
            end
         end

         // build the verdict or the end-of-log summary
         if (in_last) begin
            open = !halted_in && !ended &&
                   ((phase_in == PH_FRAME && field_byte_in != 4'd0) ||
                    phase_in == PH_PAYLOAD);
            extra.kind         = lfc_pkg::KIND_SUMMARY;
            extra.page_number  = (ended || open) ? page_in : 32'd0;
            extra.frame_status = ended ? st : (open ? lfc_pkg::ST_TRUNCATED : lfc_pkg::ST_DATA_OK);
            extra.page_count   = (ended && st == lfc_pkg::ST_COMMIT_OK) ? count_in : 32'd0;
            extra.commits_seen = commits_in;
            extra.last_of_run  = 1'b1;
            // restart for the next log
            phase_in       = PHASE_RST;
            header_left_in = HEADER_RST;
            field_byte_in  = '0;
            page_in        = '0;
            length_in      = '0;
            exp_crc_in     = '0;
            run_crc_in     = lfc_pkg::ALL_ONES;
            pos_in         = '0;
            count_in       = '0;
            commits_in     = '0;
            halted_in      = 1'b0;
            magic_ok_in    = 1'b1;
         end else if (ended) begin
            extra.kind         = lfc_pkg::KIND_VERDICT;
            extra.page_number  = page_in;
            extra.frame_status = st;
            extra.page_count   = (st == lfc_pkg::ST_COMMIT_OK) ? count_in : 32'd0;
            extra.commits_seen = commits_in;
            extra.last_of_run  = 1'b1;
         end

         // place the results in order
         if (in_last || ended) begin
            if (has_payload) begin
               push.slot1 = extra;
               push.count = 2'd2;
            end else begin
               push.slot0 = extra;
               push.count = 2'd1;
            end
         end else if (has_payload) begin
            push.slot0.last_of_run = 1'b1;
            push.count             = 2'd1;
         end
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_RST;
         header_left_ff <= HEADER_RST;
         field_byte_ff  <= '0;
         page_ff        <= '0;
         length_ff      <= '0;
         exp_crc_ff     <= '0;
         run_crc_ff     <= lfc_pkg::ALL_ONES;
         pos_ff         <= '0;
         count_ff       <= '0;
         commits_ff     <= '0;
         halted_ff      <= 1'b0;
         magic_ok_ff    <= 1'b1;
      end else begin
         phase_ff       <= phase_in;
         header_left_ff <= header_left_in;
         field_byte_ff  <= field_byte_in;
         page_ff        <= page_in;
         length_ff      <= length_in;
         exp_crc_ff     <= exp_crc_in;
         run_crc_ff     <= run_crc_in;
         pos_ff         <= pos_in;
         count_ff       <= count_in;
         commits_ff     <= commits_in;
         halted_ff      <= halted_in;
         magic_ok_ff    <= magic_ok_in;
      end
   end

   // Check the results of each item
   `LFC_ASSERT_IMP(a_last_gives_summary, clock, reset, in_accept && in_last, push.count != 2'd0 && (push.count == 2'd2 ? push.slot1.kind : push.slot0.kind) == lfc_pkg::KIND_SUMMARY, "final byte made no summary")
   `LFC_ASSERT_IMP(a_pair_starts_payload, clock, reset, push.count == 2'd2, push.slot0.kind == lfc_pkg::KIND_PAYLOAD && !push.slot0.last_of_run && push.slot1.last_of_run, "bad order of a result pair")
   `LFC_ASSERT_IMP(a_halted_silent, clock, reset, in_accept && halted_ff && !in_last, push.count == 2'd0, "halted parser made a result")

endmodule

FILE: rtl/lfc_rsp_queue.sv
// Result queue of the log frame checker: takes up to two items per cycle,
// gives one per handshake. Depends on lfc_pkg and log_frame_checker_assert.svh.
`include "log_frame_checker_assert.svh"

module lfc_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  lfc_pkg::lfc_push_type   push,
   output logic                    room,
   output lfc_pkg::lfc_result_type out_item,
   output logic                    out_valid,
   input  logic                    out_ready
);

   localparam int DEPTH    = lfc_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   lfc_pkg::lfc_result_type queue_ff [DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in, wr_nxt;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    pop;

   // Advance pointers and fill count
   always_comb begin
      pop       = out_valid && out_ready;
      wr_nxt    = wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      cnt_in    = cnt_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   assign out_valid = (cnt_ff != '0);
   assign out_item  = queue_ff[rd_ptr_ff];
   assign room      = (cnt_ff <= CNT_BITS'(DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store pushed items
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         queue_ff[wr_nxt] <= push.slot1;
      end
   end

   `LFC_ASSERT_IMP(a_no_overflow, clock, reset, push.count != 2'd0, cnt_ff <= CNT_BITS'(DEPTH - 2), "push into a full queue")
   `LFC_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_BITS'(DEPTH), "fill count beyond depth")
   `LFC_ASSERT_NXT(a_pop_only, clock, reset, pop && push.count == 2'd0, cnt_ff == $past(cnt_ff) - 1'b1, "pop did not lower the count")

endmodule

FILE: rtl/log_frame_checker.sv
// Top level of the log frame checker: configuration registers, parser and
// result queue. Depends on lfc_pkg, lfc_parser and lfc_rsp_queue.
//
//   channel  direction  handshake               payload
//   req_     in         req_tvalid/req_tready   tdata byte_in, tlast last_byte
//   rsp_     out        rsp_tvalid/rsp_tready   tdata result fields, tuser kind,
//                                               tlast last_of_run
//   csr_     in         csr_valid/csr_ready     csr_index, csr_data
//
// While req_tready is high one byte is taken per cycle; its results enter a
// four-item queue at the same edge, the first offered the next cycle if the
// queue was empty. A byte that ends a frame or the log inside a payload makes
// two items, sent one per handshake; req_tready drops while more than two wait.
// Synchronous reset clears all control state at once; no clearing pass is needed.
// csr_ready is always high; writes take effect at the next edge.
module log_frame_checker #(
   parameter int HEADER_BYTES  = lfc_pkg::HEADER_BYTES_DEF,
   parameter int POSITION_BITS = lfc_pkg::POSITION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // byte_in [7:0]
   input  logic [7:0]                        req_tdata,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // page_number [31:0], data_byte [39:32], byte_index [55:40],
   // frame_status [58:56], page_count [90:59], commits_seen [106:91], zero
   output logic [lfc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // kind [1:0]
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                       csr_data
);

   logic [31:0]             commit_marker_ff, commit_marker_in;
   logic [15:0]             max_payload_ff, max_payload_in;
   logic                    room;
   lfc_pkg::lfc_push_type   push;
   lfc_pkg::lfc_result_type rsp_item;

   assign csr_ready  = 1'b1;
   assign req_tready = room;

   // Decode configuration writes
   always_comb begin
      commit_marker_in = commit_marker_ff;
      max_payload_in   = max_payload_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lfc_pkg::CSR_COMMIT_MARKER: commit_marker_in = csr_data;
            lfc_pkg::CSR_MAX_PAYLOAD:   max_payload_in   = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         commit_marker_ff <= lfc_pkg::COMMIT_MARKER_RST;
         max_payload_ff   <= lfc_pkg::MAX_PAYLOAD_RST;
      end else begin
         commit_marker_ff <= commit_marker_in;
         max_payload_ff   <= max_payload_in;
      end
   end

   lfc_parser #(
      .HEADER_BYTES  (HEADER_BYTES),
      .POSITION_BITS (POSITION_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .in_accept     (req_tvalid && req_tready),
      .in_byte       (req_tdata),
      .in_last       (req_tlast),
      .commit_marker (commit_marker_ff),
      .max_payload   (max_payload_ff),
      .push          (push)
   );

   lfc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_item  (rsp_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready)
   );

   // Pack the result fields
   assign rsp_tdata = {5'd0, rsp_item.commits_seen, rsp_item.page_count,
                       rsp_item.frame_status, rsp_item.byte_index,
                       rsp_item.data_byte, rsp_item.page_number};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last_of_run;

endmodule
